/* hdl/tte_pkg.sv */
package tte_pkg;

  // Telnet command and option codes
  localparam logic [7:0] T_SE   = 8'd240;
  localparam logic [7:0] T_SB   = 8'd250;
  localparam logic [7:0] T_WILL = 8'd251;
  localparam logic [7:0] T_DO   = 8'd253;
  localparam logic [7:0] T_DONT = 8'd254;
  localparam logic [7:0] T_IAC  = 8'd255;

  localparam logic [7:0] OPTION_ECHO = 8'd1;
  localparam logic [7:0] OPT_SGA  = 8'd3;
  localparam logic [7:0] OPT_NAWS = 8'd31;

  localparam logic [7:0] KEY_ESC  = 8'h1B;
  localparam logic [7:0] KEY_CR   = 8'd13;
  localparam logic [7:0] KEY_LF   = 8'd10;
  localparam logic [7:0] KEY_INTR = 8'd3;
  localparam logic [7:0] KEY_NONE = 8'd0;
  localparam logic [7:0] KEY_CMD_QUIT = 8'h71;  // 'q'
  localparam logic [7:0] KEY_CMD_ECHO = 8'h65;  // 'e'
  localparam logic [7:0] KEY_CMD_CRLF = 8'h6E;  // 'n'
  localparam logic [7:0] KEY_CMD_NEG  = 8'h74;  // 't'
  localparam logic [7:0] KEY_CMD_INTR = 8'h63;  // 'c'

  localparam logic [7:0] PEND_NONE = 8'd0;

  // Result destinations
  localparam logic [1:0] DEST_DISPLAY = 2'd0;
  localparam logic [1:0] DEST_LINK    = 2'd1;
  localparam logic [1:0] DEST_STOP    = 2'd2;

  localparam logic MODE_KEYBOARD = 1'b0;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_ROWS    = 1'd1;
  localparam logic [15:0] WINDOW_COLUMNS_RESET = 16'd40;
  localparam logic [15:0] WINDOW_ROWS_RESET    = 16'd8;

  // Job kinds handed from the front to the back
  localparam logic [2:0] K_DISP   = 3'd0;  // display one byte
  localparam logic [2:0] K_LINK   = 3'd1;  // send one byte, optional echo first
  localparam logic [2:0] K_CRLF   = 3'd2;  // send CR LF, optional echo of LF first
  localparam logic [2:0] K_STOP   = 3'd3;  // stop request
  localparam logic [2:0] K_SGA    = 3'd4;  // IAC DO SGA IAC WILL NAWS
  localparam logic [2:0] K_NAWS   = 3'd5;  // window size reply
  localparam logic [2:0] K_DOECHO = 3'd6;  // IAC DO ECHO

  localparam int QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       echo;
  } job_t;

endpackage

/* hdl/tte_front.sv */
module tte_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic              mode,
  input  logic [7:0]        data_byte,
  output logic              job_valid,
  output tte_pkg::job_t     job
);

  logic       command_mode, command_mode_next;
  logic       local_echo, local_echo_next;
  logic       crlf_mode, crlf_mode_next;
  logic       after_iac, after_iac_next;
  logic [7:0] pending_command, pending_command_next;
  logic       in_escape_seq, in_escape_seq_next;
  logic       handled;
  logic       is_letter;

  assign is_letter = (data_byte >= 8'h61 && data_byte <= 8'h7A) ||
                     (data_byte >= 8'h41 && data_byte <= 8'h5A);

  always_comb begin
    command_mode_next    = command_mode;
    local_echo_next      = local_echo;
    crlf_mode_next       = crlf_mode;
    after_iac_next       = after_iac;
    pending_command_next = pending_command;
    in_escape_seq_next   = in_escape_seq;
    job_valid            = 1'b0;
    job.kind             = tte_pkg::K_DISP;
    job.data             = data_byte;
    job.echo             = 1'b0;
    handled              = 1'b0;
    if (mode == tte_pkg::MODE_KEYBOARD) begin
      if (data_byte == tte_pkg::KEY_NONE) begin
        handled = 1'b1;
      end else if (data_byte == tte_pkg::KEY_ESC) begin
        command_mode_next = !command_mode;
      end else if (command_mode) begin
        if (data_byte == tte_pkg::KEY_CMD_QUIT) begin
          job_valid = 1'b1;
          job.kind  = tte_pkg::K_STOP;
        end else begin
          command_mode_next = 1'b0;
          if (data_byte == tte_pkg::KEY_CMD_ECHO) begin
            local_echo_next = !local_echo;
          end else if (data_byte == tte_pkg::KEY_CMD_CRLF) begin
            crlf_mode_next = !crlf_mode;
          end else if (data_byte == tte_pkg::KEY_CMD_NEG) begin
            job_valid = 1'b1;
            job.kind  = tte_pkg::K_SGA;
          end else if (data_byte == tte_pkg::KEY_CMD_INTR) begin
            job_valid = 1'b1;
            job.kind  = tte_pkg::K_LINK;
            job.data  = tte_pkg::KEY_INTR;
          end
        end
      end else begin
        job_valid = 1'b1;
        job.echo  = local_echo;
        job.kind  = (data_byte == tte_pkg::KEY_LF && crlf_mode) ? tte_pkg::K_CRLF
                                                                 : tte_pkg::K_LINK;
      end
    end else begin
      if (after_iac) begin
        after_iac_next = 1'b0;
        handled        = 1'b1;
        if (data_byte == tte_pkg::T_IAC) begin
          job_valid = 1'b1;
          job.kind  = tte_pkg::K_DISP;
        end else if (data_byte == tte_pkg::T_SB) begin
          pending_command_next = tte_pkg::T_SB;
        end else if (data_byte == tte_pkg::T_SE) begin
          pending_command_next = tte_pkg::PEND_NONE;
        end else if (data_byte >= tte_pkg::T_WILL && data_byte <= tte_pkg::T_DONT) begin
          pending_command_next = data_byte;
        end else begin
          handled = 1'b0;
        end
      end
      if (!handled) begin
        if (pending_command != tte_pkg::PEND_NONE) begin
          if (pending_command >= tte_pkg::T_WILL) begin
            if (pending_command == tte_pkg::T_DO && data_byte == tte_pkg::OPT_NAWS) begin
              job_valid = 1'b1;
              job.kind  = tte_pkg::K_NAWS;
            end
            if (pending_command == tte_pkg::T_WILL && data_byte == tte_pkg::OPTION_ECHO) begin
              local_echo_next = 1'b0;
              job_valid       = 1'b1;
              job.kind        = tte_pkg::K_DOECHO;
            end
            pending_command_next = tte_pkg::PEND_NONE;
          end else if (data_byte == tte_pkg::T_IAC) begin
            after_iac_next = 1'b1;
          end
        end else if (data_byte == tte_pkg::T_IAC) begin
          after_iac_next = 1'b1;
        end else if (data_byte == tte_pkg::KEY_ESC) begin
          in_escape_seq_next = 1'b1;
        end else if (in_escape_seq) begin
          if (is_letter) begin
            in_escape_seq_next = 1'b0;
          end
        end else if (data_byte != tte_pkg::KEY_CR) begin
          job_valid = 1'b1;
          job.kind  = tte_pkg::K_DISP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_mode    <= 1'b0;
      local_echo      <= 1'b0;
      crlf_mode       <= 1'b1;
      after_iac       <= 1'b0;
      pending_command <= tte_pkg::PEND_NONE;
      in_escape_seq   <= 1'b0;
    end else if (fire) begin
      command_mode    <= command_mode_next;
      local_echo      <= local_echo_next;
      crlf_mode       <= crlf_mode_next;
      after_iac       <= after_iac_next;
      pending_command <= pending_command_next;
      in_escape_seq   <= in_escape_seq_next;
    end
  end

endmodule

/* hdl/tte_queue.sv */
module tte_queue #(
  parameter int DEPTH = tte_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tte_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output tte_pkg::job_t head_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tte_pkg::job_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == FULL_CNT);
  assign not_empty = (count != '0);
  assign head_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/tte_back.sv */
module tte_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_ready,
  input  tte_pkg::job_t head_job,
  output logic          job_take,
  input  logic [15:0]   window_columns,
  input  logic [15:0]   window_rows,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    destination,
  output logic [7:0]    out_byte,
  output logic          last_of_run
);

  tte_pkg::job_t cur;
  logic          cur_valid;
  logic [3:0]    idx;
  logic [3:0]    len;
  logic [3:0]    pos;
  logic          out_free;
  logic          emit;
  logic          last;
  logic [1:0]    item_dest;
  logic [7:0]    item_byte;

  always_comb begin
    case (cur.kind)
      tte_pkg::K_CRLF:   len = 4'd2;
      tte_pkg::K_SGA:    len = 4'd6;
      tte_pkg::K_NAWS:   len = 4'd9;
      tte_pkg::K_DOECHO: len = 4'd3;
      default:           len = 4'd1;
    endcase
    len = len + {3'd0, cur.echo};
  end

  assign pos = idx - {3'd0, cur.echo};

  always_comb begin
    item_dest = tte_pkg::DEST_LINK;
    item_byte = cur.data;
    if (cur.echo && idx == 4'd0) begin
      item_dest = tte_pkg::DEST_DISPLAY;
    end else begin
      case (cur.kind)
        tte_pkg::K_DISP: item_dest = tte_pkg::DEST_DISPLAY;
        tte_pkg::K_LINK: item_byte = cur.data;
        tte_pkg::K_CRLF: item_byte = (pos == 4'd0) ? tte_pkg::KEY_CR : tte_pkg::KEY_LF;
        tte_pkg::K_STOP: begin
          item_dest = tte_pkg::DEST_STOP;
          item_byte = 8'd0;
        end
        tte_pkg::K_SGA: begin
          case (pos)
            4'd0, 4'd3: item_byte = tte_pkg::T_IAC;
            4'd1:       item_byte = tte_pkg::T_DO;
            4'd2:       item_byte = tte_pkg::OPT_SGA;
            4'd4:       item_byte = tte_pkg::T_WILL;
            default:    item_byte = tte_pkg::OPT_NAWS;
          endcase
        end
        tte_pkg::K_NAWS: begin
          case (pos)
            4'd0, 4'd7: item_byte = tte_pkg::T_IAC;
            4'd1:       item_byte = tte_pkg::T_SB;
            4'd2:       item_byte = tte_pkg::OPT_NAWS;
            4'd3:       item_byte = window_columns[15:8];
            4'd4:       item_byte = window_columns[7:0];
            4'd5:       item_byte = window_rows[15:8];
            4'd6:       item_byte = window_rows[7:0];
            default:    item_byte = tte_pkg::T_SE;
          endcase
        end
        default: begin
          case (pos)
            4'd0:    item_byte = tte_pkg::T_IAC;
            4'd1:    item_byte = tte_pkg::T_DO;
            default: item_byte = tte_pkg::OPTION_ECHO;
          endcase
        end
      endcase
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign emit     = out_free && cur_valid;
  assign last     = (idx == len - 4'd1);
  assign job_take = job_ready && (!cur_valid || (emit && last));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= 4'd0;
    end else begin
      if (out_free) begin
        out_valid <= cur_valid;
      end
      if (job_take) begin
        cur_valid <= 1'b1;
        idx       <= 4'd0;
      end else if (emit && last) begin
        cur_valid <= 1'b0;
      end else if (emit) begin
        idx <= idx + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= head_job;
    end
    if (emit) begin
      destination <= item_dest;
      out_byte    <= item_byte;
      last_of_run <= last;
    end
  end

endmodule

/* hdl/telnet_terminal_byte_engine_unit.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  mode, data_byte
// out       output     out_valid / out_stall destination, out_byte, last_of_run
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Cycles: one result leaves per cycle while out_stall is low; a queued job yields
// 1 to 9 results, which the result serializer emits in order.
// The front classifies an item and queues any job it yields in the cycle it is accepted.
// Reset: synchronous, active high; resets terminal state and window size, clears queue and output.
// Stalls: in_stall rises only when the job queue is full; out_stall holds
// the output register and the serializer while the front keeps filling.
module telnet_terminal_byte_engine_unit #(
  parameter int QUEUE_DEPTH = tte_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      destination,
  output logic [7:0]                      out_byte,
  output logic                            last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tte_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data
);

  logic          in_fire;
  logic          job_valid;
  tte_pkg::job_t job;
  logic          q_full;
  logic          q_not_empty;
  tte_pkg::job_t head_job;
  logic          job_take;
  logic [15:0]   window_columns;
  logic [15:0]   window_rows;

  // Accept a transaction whenever the queue has room.
  assign in_stall  = q_full;
  assign in_fire   = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  // Hold the window size reported in the NAWS reply.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_columns <= tte_pkg::WINDOW_COLUMNS_RESET;
      window_rows    <= tte_pkg::WINDOW_ROWS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tte_pkg::CFG_WINDOW_COLUMNS: window_columns <= cfg_data;
        tte_pkg::CFG_WINDOW_ROWS:    window_rows    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: track terminal and telnet parser state, classify each byte.
  tte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .fire      (in_fire),
    .mode      (mode),
    .data_byte (data_byte),
    .job_valid (job_valid),
    .job       (job)
  );

  // Decouple classification from result serialization.
  tte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_fire && job_valid),
    .push_job  (job),
    .pop       (job_take),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back: expand each job into its result transactions.
  tte_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_ready      (q_not_empty),
    .head_job       (head_job),
    .job_take       (job_take),
    .window_columns (window_columns),
    .window_rows    (window_rows),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .destination    (destination),
    .out_byte       (out_byte),
    .last_of_run    (last_of_run)
  );

endmodule

/* hdl/tte_checker.sv */
module tte_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] destination,
  input logic [7:0] out_byte,
  input logic       last_of_run
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(destination)
      && $stable(last_of_run))
    else $error("stalled result changed");

  a_dest_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> destination != 2'd3)
    else $error("illegal destination");

  a_stop_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && destination == tte_pkg::DEST_STOP |-> last_of_run && out_byte == 8'd0)
    else $error("malformed stop request");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind telnet_terminal_byte_engine_unit tte_checker u_tte_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .destination (destination),
  .out_byte    (out_byte),
  .last_of_run (last_of_run)
);
